>>> design/sbag_pkg.sv
package sbag_pkg;

  localparam int ADDR_BITS_DEF      = 22;
  localparam int MAX_SPRITE_DIM_DEF = 1024;

  localparam int OUT_ADDR_W  = 22;
  localparam int PIX_W       = 8;
  localparam int LW_W        = 12;
  localparam int ORG_W       = 11;
  localparam int DIM_REG_W   = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam int X_FLIP_BIT = 0;
  localparam int Y_FLIP_BIT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_LINE_WIDTH    = 3'd2,
    REG_SPRITE_WIDTH  = 3'd3,
    REG_SPRITE_HEIGHT = 3'd4,
    REG_BLIT_MODE     = 3'd5,
    REG_MIRROR_BITS   = 3'd6,
    REG_KEY_COLOR     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_FLIP  = 2'd1,
    MODE_SCALE = 2'd2
  } blit_mode_t;

  typedef struct packed {
    logic [LW_W-1:0]  line_width;
    logic [PIX_W-1:0] key_color;
    blit_mode_t       mode;
    logic             xflip;
    logic             yflip;
  } cfg_t;

endpackage

>>> design/sbag_if.sv
interface sbag_in_if;
  import sbag_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

interface sbag_out_if;
  import sbag_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] write_address;
  logic [PIX_W-1:0]      write_pixel;
  logic                  last_of_run;

  modport source (output valid, output write_address, output write_pixel,
                  output last_of_run, input ready);
  modport sink   (input valid, input write_address, input write_pixel,
                  input last_of_run, output ready);
endinterface

>>> design/sbag_cfg_regs.sv
module sbag_cfg_regs #(
  parameter int ADDR_BITS      = sbag_pkg::ADDR_BITS_DEF,
  parameter int MAX_SPRITE_DIM = sbag_pkg::MAX_SPRITE_DIM_DEF,
  parameter int DIM_W          = $clog2(MAX_SPRITE_DIM) + 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sbag_pkg::cfg_t                   cfg,
  output logic [DIM_W-1:0]                 width,
  output logic [DIM_W-1:0]                 height,
  output logic [ADDR_BITS-1:0]             start_ptr,
  output logic                             restart
);
  import sbag_pkg::*;

  localparam int CMP_W  = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam int RIDX_W = CMP_W + 1;

  logic [ORG_W-1:0]     origin_x_r, origin_y_r;
  logic [LW_W-1:0]      line_width_r;
  logic [DIM_REG_W-1:0] sprite_width_r, sprite_height_r;
  logic [1:0]           blit_mode_r, mirror_bits_r;
  logic [PIX_W-1:0]     key_color_r;

  logic [DIM_W-1:0]     width_r, height_r, width_nxt, height_nxt;
  logic [ADDR_BITS-1:0] start_ptr_r, start_ptr_nxt;
  blit_mode_t           mode_r, mode_nxt;
  logic                 xflip_r, yflip_r, xflip_nxt, yflip_nxt;

  logic [CMP_W-1:0]     sw_ext, sh_ext, h_cl;
  logic [RIDX_W-1:0]    row_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      line_width_r    <= LW_W'(640);
      sprite_width_r  <= DIM_REG_W'(1);
      sprite_height_r <= DIM_REG_W'(1);
      blit_mode_r     <= '0;
      mirror_bits_r   <= '0;
      key_color_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:      origin_x_r      <= cfg_wdata[ORG_W-1:0];
        REG_ORIGIN_Y:      origin_y_r      <= cfg_wdata[ORG_W-1:0];
        REG_LINE_WIDTH:    line_width_r    <= cfg_wdata[LW_W-1:0];
        REG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[DIM_REG_W-1:0];
        REG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[DIM_REG_W-1:0];
        REG_BLIT_MODE:     blit_mode_r     <= cfg_wdata[1:0];
        REG_MIRROR_BITS:   mirror_bits_r   <= cfg_wdata[1:0];
        REG_KEY_COLOR:     key_color_r     <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (blit_mode_r)
      MODE_FLIP:  mode_nxt = MODE_FLIP;
      MODE_SCALE: mode_nxt = MODE_SCALE;
      default:    mode_nxt = MODE_COPY;
    endcase
    xflip_nxt = (mode_nxt == MODE_FLIP) && mirror_bits_r[X_FLIP_BIT];
    yflip_nxt = (mode_nxt == MODE_FLIP) && mirror_bits_r[Y_FLIP_BIT];

    sw_ext = CMP_W'(sprite_width_r);
    sh_ext = CMP_W'(sprite_height_r);
    if (sw_ext == '0) begin
      width_nxt = DIM_W'(1);
    end else if (sw_ext > CMP_W'(MAX_SPRITE_DIM)) begin
      width_nxt = DIM_W'(MAX_SPRITE_DIM);
    end else begin
      width_nxt = DIM_W'(sw_ext);
    end
    if (sh_ext == '0) begin
      h_cl = CMP_W'(1);
    end else if (sh_ext > CMP_W'(MAX_SPRITE_DIM)) begin
      h_cl = CMP_W'(MAX_SPRITE_DIM);
    end else begin
      h_cl = sh_ext;
    end
    height_nxt = DIM_W'(h_cl);

    // bottom row first when mirrored vertically
    row_idx = RIDX_W'(origin_y_r) + (yflip_nxt ? RIDX_W'(h_cl - CMP_W'(1)) : '0);
    start_ptr_nxt = ADDR_BITS'(row_idx) * ADDR_BITS'(line_width_r)
                  + ADDR_BITS'(origin_x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_W'(1);
      height_r    <= DIM_W'(1);
      start_ptr_r <= '0;
      mode_r      <= MODE_COPY;
      xflip_r     <= 1'b0;
      yflip_r     <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      start_ptr_r <= start_ptr_nxt;
      mode_r      <= mode_nxt;
      xflip_r     <= xflip_nxt;
      yflip_r     <= yflip_nxt;
    end
  end

  assign cfg.line_width = line_width_r;
  assign cfg.key_color  = key_color_r;
  assign cfg.mode       = mode_r;
  assign cfg.xflip      = xflip_r;
  assign cfg.yflip      = yflip_r;
  assign width          = width_r;
  assign height         = height_r;
  assign start_ptr      = start_ptr_r;
  assign restart        = cfg_we;

endmodule

>>> design/sbag_run_buf.sv
module sbag_run_buf #(
  parameter int ADDR_BITS = sbag_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [ADDR_BITS-1:0]         base_addr,
  input  logic [ADDR_BITS-1:0]         next_row_addr,
  input  logic [sbag_pkg::PIX_W-1:0]   pixel,
  input  logic                         quad,
  output logic                         load_ready,
  sbag_out_if.source                   out_ch
);
  import sbag_pkg::*;

  logic                 valid_r, quad_r;
  logic [1:0]           beat_r;
  logic [ADDR_BITS-1:0] a_r, alw_r, beat_base;
  logic [PIX_W-1:0]     pix_r;
  logic                 last, xfer;

  assign last       = !quad_r || (beat_r == 2'd3);
  assign xfer       = valid_r && out_ch.ready;
  assign load_ready = !valid_r || (xfer && last);

  // beat order: (row,2c) (row,2c+1) (row+1,2c) (row+1,2c+1)
  assign beat_base            = beat_r[1] ? alw_r : a_r;
  assign out_ch.valid         = valid_r;
  assign out_ch.write_address = OUT_ADDR_W'(beat_base + ADDR_BITS'(beat_r[0]));
  assign out_ch.write_pixel   = pix_r;
  assign out_ch.last_of_run   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
      quad_r  <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
      quad_r  <= quad;
    end else if (xfer && last) begin
      valid_r <= 1'b0;
    end else if (xfer) begin
      beat_r <= beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= base_addr;
      alw_r <= next_row_addr;
      pix_r <= pixel;
    end
  end

`ifndef NO_ASSERTIONS
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !quad_r |-> beat_r == 2'd0)
    else $error("beat counter moved on a single-write run");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> load_ready)
    else $error("run loaded while previous run still pending");
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.write_address)
      && $stable(out_ch.write_pixel) && $stable(out_ch.last_of_run))
    else $error("pending write changed before its transfer");
`endif

endmodule

>>> design/sprite_blit_address_generator_top.sv
// An accepted pixel is held in the s1 register, then loaded into the run buffer.
// Throughput: one pixel per cycle in copy and flip modes while out_ch is ready;
// in scaled mode each pixel makes four writes, one at a time, on the single result port.
// Keyed pixels leave no result and do not wait for the result port.
// Reset: rst_n synchronous, active low; loads register defaults, clears counters.
module sprite_blit_address_generator_top #(
  parameter int ADDR_BITS      = sbag_pkg::ADDR_BITS_DEF,
  parameter int MAX_SPRITE_DIM = sbag_pkg::MAX_SPRITE_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sbag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sbag_in_if.sink                         in_ch,
  sbag_out_if.source                      out_ch
);
  import sbag_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPRITE_DIM);
  localparam int DIM_W = CNT_W + 1;

  cfg_t                 cfg;
  logic [DIM_W-1:0]     width, height;
  logic [ADDR_BITS-1:0] start_ptr;
  logic                 restart;

  logic                 s1_valid_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [CNT_W-1:0]     col_r, row_r, col_nxt, row_nxt;
  logic [ADDR_BITS-1:0] row_ptr_r, row_ptr_nxt;

  logic                 in_xfer, s1_take, keyed, run_ready, start;
  logic [DIM_W-1:0]     col_inc, row_inc, dcol;
  logic                 col_wrap;
  logic [ADDR_BITS-1:0] rp, lw_a, base_addr, next_row_addr;

  sbag_cfg_regs #(
    .ADDR_BITS      (ADDR_BITS),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
    .DIM_W          (DIM_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .width     (width),
    .height    (height),
    .start_ptr (start_ptr),
    .restart   (restart)
  );

  assign keyed        = (cfg.mode == MODE_FLIP) && (s1_pix_r == cfg.key_color);
  assign s1_take      = s1_valid_r && (keyed || run_ready);
  assign in_ch.ready  = !s1_valid_r || s1_take;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    lw_a  = ADDR_BITS'(cfg.line_width);
    start = (col_r == '0) && (row_r == '0);
    rp    = start ? start_ptr : row_ptr_r;

    dcol = cfg.xflip ? (width - DIM_W'(1) - DIM_W'(col_r)) : DIM_W'(col_r);
    if (cfg.mode == MODE_SCALE) begin
      base_addr = rp + (ADDR_BITS'(col_r) << 1);
    end else begin
      base_addr = rp + ADDR_BITS'(dcol);
    end
    next_row_addr = base_addr + lw_a;

    col_inc  = DIM_W'(col_r) + DIM_W'(1);
    row_inc  = DIM_W'(row_r) + DIM_W'(1);
    col_wrap = col_inc >= width;
    col_nxt  = col_wrap ? '0 : col_inc[CNT_W-1:0];
    row_nxt  = row_r;
    row_ptr_nxt = rp;
    if (col_wrap) begin
      row_nxt = (row_inc >= height) ? '0 : row_inc[CNT_W-1:0];
      if (cfg.mode == MODE_SCALE) begin
        row_ptr_nxt = rp + (lw_a << 1);
      end else if (cfg.yflip) begin
        row_ptr_nxt = rp - lw_a;
      end else begin
        row_ptr_nxt = rp + lw_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      row_ptr_r  <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (s1_take) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        row_ptr_r <= row_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r <= in_ch.src_pixel;
    end
  end

  sbag_run_buf #(
    .ADDR_BITS (ADDR_BITS)
  ) u_run (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_take && !keyed),
    .base_addr     (base_addr),
    .next_row_addr (next_row_addr),
    .pixel         (s1_pix_r),
    .quad          (cfg.mode == MODE_SCALE),
    .load_ready    (run_ready),
    .out_ch        (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(col_r) < width)
    else $error("column counter beyond sprite width");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(row_r) < height)
    else $error("row counter beyond sprite height");
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (col_r == '0) && (row_r == '0))
    else $error("register write did not restart the sprite");
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run |=> out_ch.valid)
    else $error("scaled run dropped before its last write");
`endif

endmodule
